// ----- design/pie_pkg.sv -----
// Shared types and constants of the PageRank iteration engine.
package pie_pkg;

  localparam int unsigned MaxNodes = 4096;
  localparam int unsigned MaxEdges = 65536;
  localparam int unsigned MaxIters = 16;
  localparam int unsigned VW = $clog2(MaxNodes);
  localparam int unsigned EW = $clog2(MaxEdges);

  // Input operation codes.
  localparam logic [1:0] OP_LOAD_VERTEX = 2'd0;
  localparam logic [1:0] OP_LOAD_EDGE   = 2'd1;
  localparam logic [1:0] OP_RUN         = 2'd2;
  localparam logic [1:0] OP_READ        = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] REG_NODE_COUNT = 2'd0;
  localparam logic [1:0] REG_ITER_COUNT = 2'd1;
  localparam logic [1:0] REG_DAMPING    = 2'd2;

  typedef enum logic [4:0] {
    DP_NONE,
    DP_LD_V,
    DP_LD_E,
    DP_SETUP,
    DP_INIT_Q,
    DP_BASE_Q,
    DP_INIT_WR,
    DP_CON_ZERO,
    DP_CON_DIV,
    DP_CON_WR,
    DP_UPD_LATCH,
    DP_E_ADD,
    DP_MUL_HI,
    DP_MUL_LO,
    DP_UPD_WR,
    DP_REPORT,
    DP_RD_SET,
    DP_RD_OUT
  } dp_op_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DIV1,
    ST_DIV2,
    ST_BASE,
    ST_INIT,
    ST_C_WAIT,
    ST_C_CHK,
    ST_C_DIV,
    ST_U_WAIT,
    ST_U_LATCH,
    ST_U_CHK,
    ST_E_A,
    ST_E_B,
    ST_E_C,
    ST_MUL_HI,
    ST_MUL_LO,
    ST_U_WR,
    ST_REPORT,
    ST_R_WAIT,
    ST_R_OUT
  } state_e;

  typedef struct packed {
    dp_op_e op;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
    logic v_last;
    logic e_done;
    logic od_zero;
    logic out_free;
    logic it_last;
  } status_t;

endpackage

// ----- design/pie_div.sv -----
// Restoring divider, one quotient bit per cycle, 32-bit dividend by 17-bit divisor.
module pie_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] dividend_i,
  input  logic [16:0] divisor_i,
  output logic        busy_o,
  output logic [31:0] quotient_o
);

  logic        busy_q, busy_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [16:0] rem_q, rem_d;
  logic [31:0] quo_q, quo_d;
  logic [16:0] dsr_q, dsr_d;
  logic [17:0] trial;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dsr_d  = dsr_q;
    trial  = {rem_q, quo_q[31]};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = 5'd31;
      rem_d  = '0;
      quo_d  = dividend_i;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      if (trial >= {1'b0, dsr_q}) begin
        rem_d = 17'(trial - {1'b0, dsr_q});
        quo_d = {quo_q[30:0], 1'b1};
      end else begin
        rem_d = trial[16:0];
        quo_d = {quo_q[30:0], 1'b0};
      end
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == 5'd0) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dsr_q <= dsr_d;
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q;

endmodule

// ----- design/pie_ctrl.sv -----
// Sequencer of the PageRank iteration engine.
module pie_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic [1:0]       in_op_i,
  output logic             in_ready_o,
  input  pie_pkg::status_t status_i,
  output pie_pkg::cmd_t    cmd_o
);

  pie_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pie_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o.op   = pie_pkg::DP_NONE;
    in_ready_o = (state_q == pie_pkg::ST_IDLE);
    case (state_q)
      pie_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          case (in_op_i)
            pie_pkg::OP_LOAD_VERTEX: cmd_o.op = pie_pkg::DP_LD_V;
            pie_pkg::OP_LOAD_EDGE:   cmd_o.op = pie_pkg::DP_LD_E;
            pie_pkg::OP_RUN: begin
              cmd_o.op = pie_pkg::DP_SETUP;
              state_d  = pie_pkg::ST_DIV1;
            end
            default: begin
              cmd_o.op = pie_pkg::DP_RD_SET;
              state_d  = pie_pkg::ST_R_WAIT;
            end
          endcase
        end
      end
      pie_pkg::ST_DIV1: begin
        if (!status_i.div_busy) begin
          cmd_o.op = pie_pkg::DP_INIT_Q;
          state_d  = pie_pkg::ST_DIV2;
        end
      end
      pie_pkg::ST_DIV2: begin
        if (!status_i.div_busy) begin
          state_d = pie_pkg::ST_BASE;
        end
      end
      pie_pkg::ST_BASE: begin
        cmd_o.op = pie_pkg::DP_BASE_Q;
        state_d  = pie_pkg::ST_INIT;
      end
      pie_pkg::ST_INIT: begin
        cmd_o.op = pie_pkg::DP_INIT_WR;
        if (status_i.v_last) begin
          state_d = pie_pkg::ST_C_WAIT;
        end
      end
      pie_pkg::ST_C_WAIT: state_d = pie_pkg::ST_C_CHK;
      pie_pkg::ST_C_CHK: begin
        if (status_i.od_zero) begin
          cmd_o.op = pie_pkg::DP_CON_ZERO;
          state_d  = status_i.v_last ? pie_pkg::ST_U_WAIT : pie_pkg::ST_C_WAIT;
        end else begin
          cmd_o.op = pie_pkg::DP_CON_DIV;
          state_d  = pie_pkg::ST_C_DIV;
        end
      end
      pie_pkg::ST_C_DIV: begin
        if (!status_i.div_busy) begin
          cmd_o.op = pie_pkg::DP_CON_WR;
          state_d  = status_i.v_last ? pie_pkg::ST_U_WAIT : pie_pkg::ST_C_WAIT;
        end
      end
      pie_pkg::ST_U_WAIT: state_d = pie_pkg::ST_U_LATCH;
      pie_pkg::ST_U_LATCH: begin
        cmd_o.op = pie_pkg::DP_UPD_LATCH;
        state_d  = pie_pkg::ST_U_CHK;
      end
      pie_pkg::ST_U_CHK: begin
        state_d = status_i.e_done ? pie_pkg::ST_MUL_HI : pie_pkg::ST_E_A;
      end
      pie_pkg::ST_E_A: state_d = pie_pkg::ST_E_B;
      pie_pkg::ST_E_B: state_d = pie_pkg::ST_E_C;
      pie_pkg::ST_E_C: begin
        cmd_o.op = pie_pkg::DP_E_ADD;
        state_d  = pie_pkg::ST_U_CHK;
      end
      pie_pkg::ST_MUL_HI: begin
        cmd_o.op = pie_pkg::DP_MUL_HI;
        state_d  = pie_pkg::ST_MUL_LO;
      end
      pie_pkg::ST_MUL_LO: begin
        cmd_o.op = pie_pkg::DP_MUL_LO;
        state_d  = pie_pkg::ST_U_WR;
      end
      pie_pkg::ST_U_WR: begin
        cmd_o.op = pie_pkg::DP_UPD_WR;
        state_d  = status_i.v_last ? pie_pkg::ST_REPORT : pie_pkg::ST_U_WAIT;
      end
      pie_pkg::ST_REPORT: begin
        if (status_i.out_free) begin
          cmd_o.op = pie_pkg::DP_REPORT;
          state_d  = status_i.it_last ? pie_pkg::ST_IDLE : pie_pkg::ST_C_WAIT;
        end
      end
      pie_pkg::ST_R_WAIT: state_d = pie_pkg::ST_R_OUT;
      pie_pkg::ST_R_OUT: begin
        if (status_i.out_free) begin
          cmd_o.op = pie_pkg::DP_RD_OUT;
          state_d  = pie_pkg::ST_IDLE;
        end
      end
      default: state_d = pie_pkg::ST_IDLE;
    endcase
  end

endmodule

// ----- design/pie_dp.sv -----
// Datapath of the PageRank iteration engine: tables, stores, counters, arithmetic, output register.
module pie_dp (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  pie_pkg::cmd_t    cmd_i,
  output pie_pkg::status_t status_o,
  input  logic [12:0]      node_count_i,
  input  logic [4:0]       iteration_count_i,
  input  logic [15:0]      damping_i,
  input  logic [11:0]      vertex_index_i,
  input  logic [16:0]      out_degree_i,
  input  logic [15:0]      in_row_start_i,
  input  logic [16:0]      in_degree_i,
  input  logic [15:0]      edge_index_i,
  input  logic [11:0]      source_vertex_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic             out_kind_o,
  output logic [3:0]       out_iteration_o,
  output logic [34:0]      out_error_sum_o,
  output logic [31:0]      out_score_o,
  output logic             out_last_o
);

  localparam logic [34:0] ErrMax = {35{1'b1}};

  // Memories.
  logic [49:0] vtx_mem [pie_pkg::MaxNodes];
  logic [31:0] score_mem [pie_pkg::MaxNodes];
  logic [31:0] contrib_mem [pie_pkg::MaxNodes];
  logic [11:0] edge_mem [pie_pkg::MaxEdges];

  logic [49:0] vtx_rd_q;
  logic [31:0] score_rd_q, contrib_rd_q;
  logic [11:0] edge_rd_q;

  logic [pie_pkg::VW-1:0] v_q, v_d;
  logic [3:0]  it_q, it_d;
  logic [16:0] off_q, off_d;
  logic [15:0] start_q, start_d;
  logic [16:0] indeg_q, indeg_d;
  logic [31:0] old_q, old_d;
  logic [47:0] total_q, total_d;
  logic [47:0] hi_q, hi_d;
  logic [15:0] lo_q, lo_d;
  logic [31:0] init_q, init_d;
  logic [31:0] base_q, base_d;
  logic [34:0] err_q, err_d;

  logic        out_valid_q, out_valid_d;
  logic        kind_q, kind_d, last_q, last_d;
  logic [3:0]  iter_q, iter_d;
  logic [34:0] esum_q, esum_d;
  logic [31:0] osc_q, osc_d;

  logic [12:0] n_eff;
  logic [4:0]  it_eff;
  logic        v_last, out_free, src_ok;
  logic [pie_pkg::VW-1:0] v_next;
  logic [pie_pkg::EW-1:0] edge_addr;

  logic        div_start;
  logic [31:0] div_dvd, div_quo;
  logic [16:0] div_dsr;
  logic        div_busy;

  logic [49:0] sum_ns;
  logic [31:0] ns, diff;
  logic [35:0] err_sum;
  logic [31:0] lo_prod;

  logic        vtx_we, score_we, contrib_we, edge_we;
  logic [pie_pkg::VW-1:0] vtx_wa;
  logic [31:0] score_wd, contrib_wd;

  always_comb begin
    if (node_count_i == 13'd0) begin
      n_eff = 13'd1;
    end else if (node_count_i > 13'(pie_pkg::MaxNodes)) begin
      n_eff = 13'(pie_pkg::MaxNodes);
    end else begin
      n_eff = node_count_i;
    end
    if (iteration_count_i == 5'd0) begin
      it_eff = 5'd1;
    end else if (iteration_count_i > 5'(pie_pkg::MaxIters)) begin
      it_eff = 5'(pie_pkg::MaxIters);
    end else begin
      it_eff = iteration_count_i;
    end
  end

  assign v_last    = ({1'b0, v_q} == 13'(n_eff - 13'd1));
  assign v_next    = v_last ? '0 : v_q + 1'b1;
  assign out_free  = !out_valid_q || out_ready_i;
  assign src_ok    = ({1'b0, edge_rd_q} < n_eff);
  assign edge_addr = start_q + off_q[15:0];

  assign status_o.div_busy = div_busy;
  assign status_o.v_last   = v_last;
  assign status_o.e_done   = (off_q == indeg_q);
  assign status_o.od_zero  = (vtx_rd_q[16:0] == 17'd0);
  assign status_o.out_free = out_free;
  assign status_o.it_last  = ({1'b0, it_q} == 5'(it_eff - 5'd1));

  pie_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dsr),
    .busy_o     (div_busy),
    .quotient_o (div_quo)
  );

  always_comb begin
    sum_ns  = 50'(base_q) + 50'(hi_q) + 50'(lo_q);
    ns      = (sum_ns > 50'h0_FFFF_FFFF) ? 32'hFFFF_FFFF : sum_ns[31:0];
    diff    = (ns > old_q) ? ns - old_q : old_q - ns;
    err_sum = 36'(err_q) + 36'(diff);
    lo_prod = 32'(total_q[15:0]) * 32'(damping_i);
  end

  always_comb begin
    v_d = v_q; it_d = it_q; off_d = off_q; start_d = start_q; indeg_d = indeg_q;
    old_d = old_q; total_d = total_q; hi_d = hi_q; lo_d = lo_q;
    init_d = init_q; base_d = base_q; err_d = err_q;
    out_valid_d = out_valid_q && !out_ready_i;
    kind_d = kind_q; last_d = last_q; iter_d = iter_q; esum_d = esum_q; osc_d = osc_q;
    div_start = 1'b0;
    div_dvd   = score_rd_q;
    div_dsr   = vtx_rd_q[16:0];
    vtx_we = 1'b0; edge_we = 1'b0; score_we = 1'b0; contrib_we = 1'b0;
    vtx_wa = vertex_index_i;
    score_wd = init_q;
    contrib_wd = div_quo;
    case (cmd_i.op)
      pie_pkg::DP_LD_V: vtx_we = 1'b1;
      pie_pkg::DP_LD_E: edge_we = 1'b1;
      pie_pkg::DP_SETUP: begin
        div_start = 1'b1;
        div_dvd   = 32'h8000_0000;
        div_dsr   = 17'(n_eff);
        v_d = '0; it_d = '0; err_d = '0;
      end
      pie_pkg::DP_INIT_Q: begin
        init_d    = div_quo;
        div_start = 1'b1;
        div_dvd   = {17'(17'd65536 - 17'(damping_i)), 15'd0};
        div_dsr   = 17'(n_eff);
      end
      pie_pkg::DP_BASE_Q: base_d = div_quo;
      pie_pkg::DP_INIT_WR: begin
        score_we = 1'b1;
        v_d = v_next;
      end
      pie_pkg::DP_CON_ZERO: begin
        contrib_we = 1'b1;
        contrib_wd = '0;
        v_d = v_next;
      end
      pie_pkg::DP_CON_DIV: div_start = 1'b1;
      pie_pkg::DP_CON_WR: begin
        contrib_we = 1'b1;
        v_d = v_next;
      end
      pie_pkg::DP_UPD_LATCH: begin
        start_d = vtx_rd_q[32:17];
        indeg_d = vtx_rd_q[49:33];
        old_d   = score_rd_q;
        total_d = '0;
        off_d   = '0;
      end
      pie_pkg::DP_E_ADD: begin
        if (src_ok) begin
          total_d = total_q + 48'(contrib_rd_q);
        end
        off_d = off_q + 17'd1;
      end
      pie_pkg::DP_MUL_HI: hi_d = 48'(total_q[47:16]) * 48'(damping_i);
      pie_pkg::DP_MUL_LO: lo_d = lo_prod[31:16];
      pie_pkg::DP_UPD_WR: begin
        score_we = 1'b1;
        score_wd = ns;
        err_d = (err_sum > 36'(ErrMax)) ? ErrMax : err_sum[34:0];
        v_d = v_next;
      end
      pie_pkg::DP_REPORT: begin
        out_valid_d = 1'b1;
        kind_d = 1'b0;
        iter_d = it_q;
        esum_d = err_q;
        osc_d  = '0;
        last_d = status_o.it_last;
        err_d  = '0;
        it_d   = it_q + 4'd1;
      end
      pie_pkg::DP_RD_SET: v_d = vertex_index_i;
      pie_pkg::DP_RD_OUT: begin
        out_valid_d = 1'b1;
        kind_d = 1'b1;
        iter_d = '0;
        esum_d = '0;
        osc_d  = score_rd_q;
        last_d = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (vtx_we) vtx_mem[vtx_wa] <= {in_degree_i, in_row_start_i, out_degree_i};
    if (edge_we) edge_mem[edge_index_i] <= source_vertex_i;
    if (score_we) score_mem[v_q] <= score_wd;
    if (contrib_we) contrib_mem[v_q] <= contrib_wd;
    vtx_rd_q     <= vtx_mem[v_q];
    score_rd_q   <= score_mem[v_q];
    edge_rd_q    <= edge_mem[edge_addr];
    contrib_rd_q <= contrib_mem[edge_rd_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      v_q   <= '0;
      it_q  <= '0;
      off_q <= '0;
      indeg_q <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      v_q   <= v_d;
      it_q  <= it_d;
      off_q <= off_d;
      indeg_q <= indeg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    start_q <= start_d; old_q <= old_d; total_q <= total_d; hi_q <= hi_d; lo_q <= lo_d;
    init_q <= init_d; base_q <= base_d; err_q <= err_d;
    kind_q <= kind_d; last_q <= last_d; iter_q <= iter_d; esum_q <= esum_d; osc_q <= osc_d;
  end

  assign out_valid_o     = out_valid_q;
  assign out_kind_o      = kind_q;
  assign out_iteration_o = iter_q;
  assign out_error_sum_o = esum_q;
  assign out_score_o     = osc_q;
  assign out_last_o      = last_q;

endmodule

// ----- design/pagerank_iteration_engine_top.sv -----
// Top level of the PageRank iteration engine: stream ports, configuration registers.
//
// Pull-style PageRank engine over a graph in incoming-edge CSR form. Load
// vertex and load in-edge requests are taken one per cycle and write the
// vertex and edge tables directly. A read score request answers with one
// result through the registered store read and the output register. A run
// request seeds every score with 1/node_count using two passes of the
// shared restoring divider (the seed, then the base term) plus one store
// write per vertex, then performs iteration_count iterations, each
// reporting one error result (last is set on the final one). Per
// iteration, the contribution pass writes zero for a vertex of out-degree
// zero and otherwise waits on the one-bit-per-cycle divider; the update
// pass walks each in-edge through the chain of registered memory reads
// (edge table, then contribution store). While a run or read is in
// progress no request is taken; results wait in an output register and
// back-pressure on the result channel stalls the engine at the report and
// at the read answer. Stores and tables power up undefined; only entries
// that were loaded may be read back or referenced.
module pagerank_iteration_engine_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // tdata: vertex_index[11:0], out_degree[28:12], in_row_start[44:29],
  //        in_degree[61:45], edge_index[77:62], source_vertex[89:78]
  input  logic [95:0] s_axis_tdata_i,
  // tuser: operation[1:0]
  input  logic [1:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // tdata: iteration[3:0], error_sum[38:4], score[70:39]
  output logic [71:0] m_axis_tdata_o,
  // tuser: result_kind[0]
  output logic        m_axis_tuser_o,
  output logic        m_axis_tlast_o,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [3:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  output logic [31:0] prdata_o,
  output logic        pready_o
);

  logic [12:0] node_count_q;
  logic [4:0]  iter_count_q;
  logic [15:0] damping_q;

  pie_pkg::cmd_t    cmd;
  pie_pkg::status_t status;

  logic [3:0]  o_iter;
  logic [34:0] o_err;
  logic [31:0] o_score;

  assign pready_o = 1'b1;

  // Register writes complete in the access phase.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= 13'd4096;
      iter_count_q <= 5'd11;
      damping_q    <= 16'd55706;
    end else if (psel_i && penable_i && pwrite_i && pready_o) begin
      case (paddr_i[3:2])
        pie_pkg::REG_NODE_COUNT: node_count_q <= pwdata_i[12:0];
        pie_pkg::REG_ITER_COUNT: iter_count_q <= pwdata_i[4:0];
        pie_pkg::REG_DAMPING:    damping_q    <= pwdata_i[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr_i[3:2])
      pie_pkg::REG_NODE_COUNT: prdata_o = 32'(node_count_q);
      pie_pkg::REG_ITER_COUNT: prdata_o = 32'(iter_count_q);
      pie_pkg::REG_DAMPING:    prdata_o = 32'(damping_q);
      default:                 prdata_o = '0;
    endcase
  end

  pie_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_op_i    (s_axis_tuser_i),
    .in_ready_o (s_axis_tready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  pie_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .node_count_i      (node_count_q),
    .iteration_count_i (iter_count_q),
    .damping_i         (damping_q),
    .vertex_index_i    (s_axis_tdata_i[11:0]),
    .out_degree_i      (s_axis_tdata_i[28:12]),
    .in_row_start_i    (s_axis_tdata_i[44:29]),
    .in_degree_i       (s_axis_tdata_i[61:45]),
    .edge_index_i      (s_axis_tdata_i[77:62]),
    .source_vertex_i   (s_axis_tdata_i[89:78]),
    .out_valid_o       (m_axis_tvalid_o),
    .out_ready_i       (m_axis_tready_i),
    .out_kind_o        (m_axis_tuser_o),
    .out_iteration_o   (o_iter),
    .out_error_sum_o   (o_err),
    .out_score_o       (o_score),
    .out_last_o        (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {1'b0, o_score, o_err, o_iter};

endmodule

// ----- test/tb_pagerank_iteration_engine_top.sv -----
// Testbench of the PageRank iteration engine: predicted results checked over the streams.
`timescale 1ns / 100ps

module tb_pagerank_iteration_engine_top;

  typedef struct packed {
    logic        kind;
    logic [3:0]  iter;
    logic [34:0] err;
    logic [31:0] score;
    logic        last;
  } rank_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [95:0] s_axis_tdata_i = '0;
  logic [1:0]  s_axis_tuser_i = pie_pkg::OP_LOAD_VERTEX;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [71:0] m_axis_tdata_o;
  logic        m_axis_tuser_o;
  logic        m_axis_tlast_o;
  logic        psel_i = 1'b0;
  logic        penable_i = 1'b0;
  logic        pwrite_i = 1'b0;
  logic [3:0]  paddr_i = '0;
  logic [31:0] pwdata_i = '0;
  logic [31:0] prdata_o;
  logic        pready_o;

  pagerank_iteration_engine_top u_top (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Shadow copy of the engine's tables, stores and registers.
  bit [16:0] out_deg_tbl [pie_pkg::MaxNodes];
  bit [15:0] row_start_tbl [pie_pkg::MaxNodes];
  bit [16:0] in_deg_tbl [pie_pkg::MaxNodes];
  bit [11:0] edge_src_tbl [pie_pkg::MaxEdges];
  bit [31:0] rank_mem [pie_pkg::MaxNodes];
  bit [31:0] share_mem [pie_pkg::MaxNodes];
  bit [12:0] cfg_nodes = 13'd4096;
  bit [4:0]  cfg_iters = 5'd11;
  bit [15:0] cfg_damp = 16'd55706;

  rank_result_t rank_results_q[$];
  int unsigned  mismatches = 0;
  int unsigned  requests_sent = 0;
  bit           no_gaps = 1'b0;
  int unsigned  sink_hold = 0;
  // Vertices below this count hold a score, so reading them is legal.
  int unsigned  scored_nodes = 0;

  // Appends one expected result behind those already waiting.
  task automatic expect_result(rank_result_t r);
    rank_results_q.insert(rank_results_q.size(), r);
  endtask

  // Mirrors one run request: seeding, iterations, one report per iteration.
  task automatic predict_run();
    longint unsigned n, iters, d, base, total, scaled, ns, old, err;
    rank_result_t r;
    n = cfg_nodes;
    if (n == 0) n = 1;
    if (n > pie_pkg::MaxNodes) n = pie_pkg::MaxNodes;
    if (n > scored_nodes) scored_nodes = 32'(n);
    iters = cfg_iters;
    if (iters == 0) iters = 1;
    if (iters > pie_pkg::MaxIters) iters = pie_pkg::MaxIters;
    d = cfg_damp;
    base = ((65536 - d) << 15) / n;
    for (int v = 0; v < n; v++) rank_mem[v] = 32'((64'd1 << 31) / n);
    for (int it = 0; it < iters; it++) begin
      err = 0;
      for (int v = 0; v < n; v++)
        share_mem[v] = (out_deg_tbl[v] == 0) ? 32'd0 : rank_mem[v] / out_deg_tbl[v];
      for (int v = 0; v < n; v++) begin
        total = 0;
        for (int j = 0; j < in_deg_tbl[v]; j++) begin
          int unsigned src;
          src = edge_src_tbl[(row_start_tbl[v] + j) % pie_pkg::MaxEdges];
          if (src < n) total += share_mem[src];
        end
        scaled = (total >> 16) * d + (((total & 64'hFFFF) * d) >> 16);
        ns = base + scaled;
        if (ns > 64'hFFFF_FFFF) ns = 64'hFFFF_FFFF;
        old = rank_mem[v];
        err += (ns > old) ? ns - old : old - ns;
        if (err > (64'd1 << 35) - 1) err = (64'd1 << 35) - 1;
        rank_mem[v] = 32'(ns);
      end
      r.kind = 1'b0;
      r.iter = 4'(it);
      r.err = 35'(err);
      r.score = '0;
      r.last = (it + 1 == iters);
      expect_result(r);
    end
  endtask

  // Sends one request, waits for it to be taken and updates the prediction.
  task automatic send_request(logic [1:0] op, logic [11:0] vi, logic [16:0] od = '0,
                              logic [15:0] st = '0, logic [16:0] ind = '0,
                              logic [15:0] ei = '0, logic [11:0] sv = '0);
    int unsigned gap;
    rank_result_t r;
    gap = no_gaps ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      s_axis_tvalid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tuser_i = op;
    s_axis_tdata_i = {6'd0, sv, ei, ind, st, od, vi};
    s_axis_tvalid_i = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready_o);
    requests_sent++;
    case (op)
      pie_pkg::OP_LOAD_VERTEX: begin
        out_deg_tbl[vi] = od;
        row_start_tbl[vi] = st;
        in_deg_tbl[vi] = ind;
      end
      pie_pkg::OP_LOAD_EDGE: edge_src_tbl[ei] = sv;
      pie_pkg::OP_RUN: predict_run();
      pie_pkg::OP_READ: begin
        r = '{kind: 1'b1, iter: '0, err: '0, score: rank_mem[vi], last: 1'b1};
        expect_result(r);
      end
    endcase
    @(negedge clk_i);
  endtask

  // Lets every expected result drain, then idles the engine before returning.
  task automatic wait_drained();
    s_axis_tvalid_i = 1'b0;
    wait (rank_results_q.size() == 0);
    repeat (16) @(negedge clk_i);
  endtask

  task automatic apb_write(logic [1:0] idx, logic [31:0] value);
    @(negedge clk_i);
    psel_i = 1'b1;
    pwrite_i = 1'b1;
    paddr_i = {idx, 2'b00};
    pwdata_i = value;
    @(negedge clk_i);
    penable_i = 1'b1;
    do @(posedge clk_i); while (!pready_o);
    case (idx)
      pie_pkg::REG_NODE_COUNT: cfg_nodes = value[12:0];
      pie_pkg::REG_ITER_COUNT: cfg_iters = value[4:0];
      pie_pkg::REG_DAMPING:    cfg_damp = value[15:0];
      default: ;
    endcase
    @(negedge clk_i);
    psel_i = 1'b0;
    penable_i = 1'b0;
    pwrite_i = 1'b0;
  endtask

  task automatic set_config(logic [31:0] nodes, logic [31:0] iters, logic [31:0] damp);
    wait_drained();
    apb_write(pie_pkg::REG_NODE_COUNT, nodes);
    apb_write(pie_pkg::REG_ITER_COUNT, iters);
    apb_write(pie_pkg::REG_DAMPING, damp);
  endtask

  // Loads vertices 0..n-1 with small in-degrees whose edge slots are all loaded.
  task automatic load_small_graph(int unsigned n);
    logic [15:0] st;
    logic [16:0] ind;
    for (int v = 0; v < n; v++) begin
      st = ($urandom_range(0, 7) == 0) ? 16'hFFFF - 16'($urandom_range(0, 2))
                                       : 16'($urandom);
      ind = 17'($urandom_range(0, 4));
      send_request(pie_pkg::OP_LOAD_VERTEX, 12'(v), 17'($urandom_range(0, 7) == 0 ?
                   $urandom : $urandom_range(0, 5)), st, ind);
      for (int j = 0; j < ind; j++)
        send_request(pie_pkg::OP_LOAD_EDGE, 12'($urandom), '0, '0, '0, st + 16'(j),
                     ($urandom_range(0, 3) == 0) ? 12'($urandom)
                                                 : 12'($urandom_range(0, n)));
    end
  endtask

  // The first 64 vertices get a record and a score, so later reads below that are legal.
  task automatic test_full_graph();
    set_config(32'd64, 32'd0, 32'd65535);
    no_gaps = 1'b1;
    for (int v = 0; v < 64; v++)
      send_request(pie_pkg::OP_LOAD_VERTEX, 12'(v), 17'($urandom), 16'($urandom), '0);
    no_gaps = 1'b0;
    send_request(pie_pkg::OP_RUN, '0);
    send_request(pie_pkg::OP_READ, 12'd0);
    send_request(pie_pkg::OP_READ, 12'd63);
  endtask

  // Zero and oversized register values, wrapped edge slots, sources outside the graph.
  task automatic test_corner_cases();
    set_config(32'd0, 32'd31, 32'd0);
    send_request(pie_pkg::OP_LOAD_VERTEX, 12'd0, 17'd65536, 16'hFFFF, 17'd2);
    send_request(pie_pkg::OP_LOAD_EDGE, '0, '0, '0, '0, 16'hFFFF, 12'd0);
    send_request(pie_pkg::OP_LOAD_EDGE, '0, '0, '0, '0, 16'h0000, 12'hFFF);
    send_request(pie_pkg::OP_RUN, '0);
    send_request(pie_pkg::OP_READ, 12'd0);
    set_config(32'd3, 32'd16, 32'd65535);
    send_request(pie_pkg::OP_LOAD_VERTEX, 12'd0, 17'd0, 16'd10, 17'd3);
    send_request(pie_pkg::OP_LOAD_VERTEX, 12'd1, 17'd1, 16'd10, 17'd1);
    send_request(pie_pkg::OP_LOAD_VERTEX, 12'd2, 17'd2, 16'd11, 17'd2);
    send_request(pie_pkg::OP_LOAD_EDGE, '0, '0, '0, '0, 16'd10, 12'd1);
    send_request(pie_pkg::OP_LOAD_EDGE, '0, '0, '0, '0, 16'd11, 12'd2);
    send_request(pie_pkg::OP_LOAD_EDGE, '0, '0, '0, '0, 16'd12, 12'd2);
    // Out of the graph, so its all-ones record is never walked.
    send_request(pie_pkg::OP_LOAD_VERTEX, 12'hFFF, 17'h1FFFF, 16'hFFFF, 17'h1FFFF);
    send_request(pie_pkg::OP_RUN, '0);
    send_request(pie_pkg::OP_READ, 12'd1);
    // Beyond the graph but seeded by an earlier run.
    send_request(pie_pkg::OP_READ, 12'd63);
  endtask

  // The sink stalls through a long run while requests keep coming.
  task automatic test_backpressure();
    set_config(32'd4, 32'd16, 32'd55706);
    load_small_graph(4);
    sink_hold = 300;
    no_gaps = 1'b1;
    send_request(pie_pkg::OP_RUN, '0);
    for (int k = 0; k < 4; k++)
      send_request(pie_pkg::OP_READ, 12'($urandom_range(0, scored_nodes - 1)));
    no_gaps = 1'b0;
  endtask

  // Random graphs and settings, with stray loads and reads mixed in.
  task automatic test_random_runs();
    int unsigned n, start_count;
    start_count = requests_sent;
    while (requests_sent - start_count < 220) begin
      n = $urandom_range(1, 12);
      set_config(n, $urandom_range(1, 5), $urandom);
      no_gaps = ($urandom_range(0, 3) == 0);
      load_small_graph(n);
      for (int k = $urandom_range(0, 3); k > 0; k--) begin
        if ($urandom_range(0, 1))
          send_request(pie_pkg::OP_LOAD_VERTEX, 12'($urandom_range(16, 4095)),
                       17'($urandom), 16'($urandom), 17'($urandom));
        else
          send_request(pie_pkg::OP_READ, 12'($urandom_range(0, scored_nodes - 1)));
      end
      send_request(pie_pkg::OP_RUN, '0);
      for (int k = $urandom_range(0, 3); k > 0; k--)
        send_request(pie_pkg::OP_READ, 12'($urandom_range(0, scored_nodes - 1)));
    end
  endtask

  // Result sink: random stalls, one long hold on request, all fields checked in one compare.
  initial begin
    int unsigned stall;
    rank_result_t got, want;
    forever begin
      @(negedge clk_i);
      if (sink_hold > 0) begin
        stall = sink_hold;
        sink_hold = 0;
      end else begin
        stall = no_gaps ? 0 : $urandom_range(0, 11);
      end
      if (stall > 0) begin
        m_axis_tready_i = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready_i = 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
      got = '{kind: m_axis_tuser_o, iter: m_axis_tdata_o[3:0],
              err: m_axis_tdata_o[38:4], score: m_axis_tdata_o[70:39],
              last: m_axis_tlast_o};
      if (rank_results_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result %p", got);
      end else begin
        want = rank_results_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("Mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

  initial begin
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    test_full_graph();
    test_corner_cases();
    test_backpressure();
    test_random_runs();
    wait_drained();
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
